/* hdl/dmc_pkg.sv */
package dmc_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int StackDepth = ((MaxWidth + 1) / 2) * ((MaxHeight + 1) / 2);
  localparam int StackAw    = $clog2(StackDepth);
  localparam int DepthW     = 11;
  localparam int CfgW       = 7;
  localparam int CoordW     = 6;
  localparam int StackW     = RowW + ColW;

  typedef logic [MaxWidth-1:0] row_t;

  localparam logic [2:0] StatCarved    = 3'd0;
  localparam logic [2:0] StatBacktrack = 3'd1;
  localparam logic [2:0] StatFinished  = 3'd2;
  localparam logic [2:0] StatStarted   = 3'd3;
  localparam logic [2:0] StatRejected  = 3'd4;

  localparam logic RegGridWidth  = 1'b0;
  localparam logic RegGridHeight = 1'b1;

  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  typedef enum logic [1:0] {
    DirLeft  = 2'd0,
    DirRight = 2'd1,
    DirUp    = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  typedef struct packed {
    logic              action;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [7:0]        random_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CoordW-1:0] wall_x;
    logic [CoordW-1:0] wall_y;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [DepthW-1:0] depth;
  } rsp_t;

endpackage

/* hdl/dfs_maze_carver_unit.sv */
// channel   | signals                              | handshake
// ----------+--------------------------------------+---------------------------------
// request   | start, busy, req_i (req_t)           | taken when start && !busy
// result    | done_o, rsp_o (rsp_t)                | one-cycle strobe, no back-pressure
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i     | written when cfg_we_i is high
//
// Map is one row word per grid row in a 64x64-bit RAM; the path stack is a 1024x12 RAM.
// Start: a sweep that rewrites every map row, then the result strobe.
// Step: 3 row reads (mid, up, down), then one row write; a vertical carve also reads
// and writes the wall row; a backtrack pops instead; empty stack, bad start: from idle.
// Reset clears stack depth and control; the map needs no pass since steps only run
// after a start has swept it.
// busy stays high until the result strobe; the receiver cannot stall results.
module dfs_maze_carver_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dmc_pkg::req_t                   req_i,
  output logic                            done_o,
  output dmc_pkg::rsp_t                   rsp_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [dmc_pkg::CfgW-1:0]        cfg_wdata_i
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SClear = 3'd1;
  localparam logic [2:0] SRdUp  = 3'd2;
  localparam logic [2:0] SRdDn  = 3'd3;
  localparam logic [2:0] SEval  = 3'd4;
  localparam logic [2:0] SWrN   = 3'd5;
  localparam logic [2:0] SWrW   = 3'd6;
  localparam logic [2:0] SPop   = 3'd7;

  localparam logic [dmc_pkg::RowW-1:0] LastRow = dmc_pkg::RowW'(dmc_pkg::MaxHeight - 1);
  localparam logic [dmc_pkg::CfgW-1:0] MaxW    = dmc_pkg::CfgW'(dmc_pkg::MaxWidth);
  localparam logic [dmc_pkg::CfgW-1:0] MaxH    = dmc_pkg::CfgW'(dmc_pkg::MaxHeight);
  localparam logic [dmc_pkg::DepthW-1:0] FullDepth =
    dmc_pkg::DepthW'(dmc_pkg::StackDepth);
  localparam dmc_pkg::row_t OneBit = dmc_pkg::row_t'(1);

  logic [2:0]                   state_q, state_d;
  logic [dmc_pkg::RowW-1:0]     clr_q, clr_d;
  logic [dmc_pkg::DepthW-1:0]   cnt_q, cnt_d;
  logic [dmc_pkg::CfgW-1:0]     grid_w_q, grid_h_q;
  logic                         done_q, done_d;

  logic [dmc_pkg::CoordW-1:0]   top_x_q, top_x_d, top_y_q, top_y_d;
  logic [dmc_pkg::CoordW-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [7:0]                   rnd_q, rnd_d;
  dmc_pkg::row_t                row_mid_q, row_mid_d, row_up_q, row_up_d;
  dmc_pkg::row_t                row_dn_q, row_dn_d;
  logic [dmc_pkg::CoordW-1:0]   nx_q, nx_d, ny_q, ny_d, wx_q, wx_d, wy_q, wy_d;
  dmc_pkg::dir_e                dir_q, dir_d;
  dmc_pkg::rsp_t                rsp_q, rsp_d;

  logic                         map_we;
  logic [dmc_pkg::RowW-1:0]     map_waddr, map_raddr;
  dmc_pkg::row_t                map_wdata, map_rdata;
  logic                         stk_we;
  logic [dmc_pkg::StackAw-1:0]  stk_waddr, stk_raddr;
  logic [dmc_pkg::StackW-1:0]   stk_wdata, stk_rdata;

  logic [dmc_pkg::CfgW-1:0]     w_eff, h_eff;
  logic [3:0]                   cand;
  logic [2:0]                   n_cand;
  logic [10:0]                  prod;
  logic [1:0]                   pick;
  dmc_pkg::dir_e                pick_dir;
  logic [2:0]                   seen;
  logic                         found;
  logic                         x_ok, y_ok;
  logic [dmc_pkg::DepthW-1:0]   cnt_dec;
  dmc_pkg::row_t                src_row;

  assign busy   = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // saturate the sizes to 1..max
  assign w_eff = (grid_w_q == '0) ? dmc_pkg::CfgW'(1) : ((grid_w_q > MaxW) ? MaxW : grid_w_q);
  assign h_eff = (grid_h_q == '0) ? dmc_pkg::CfgW'(1) : ((grid_h_q > MaxH) ? MaxH : grid_h_q);

  // top cell may be outside the grid after a size change
  assign x_ok = ({1'b0, top_x_q} < w_eff);
  assign y_ok = ({1'b0, top_y_q} < h_eff);

  always_comb begin
    cand[dmc_pkg::DirLeft]  = (top_x_q >= dmc_pkg::CoordW'(2)) && y_ok &&
                              ({1'b0, top_x_q - dmc_pkg::CoordW'(2)} < w_eff) &&
                              !row_mid_q[top_x_q - dmc_pkg::CoordW'(2)];
    cand[dmc_pkg::DirRight] = (({1'b0, top_x_q} + dmc_pkg::CfgW'(2)) < w_eff) && y_ok &&
                              !row_mid_q[top_x_q + dmc_pkg::CoordW'(2)];
    cand[dmc_pkg::DirUp]    = (top_y_q >= dmc_pkg::CoordW'(2)) && x_ok &&
                              ({1'b0, top_y_q - dmc_pkg::CoordW'(2)} < h_eff) &&
                              !row_up_q[top_x_q];
    cand[dmc_pkg::DirDown]  = (({1'b0, top_y_q} + dmc_pkg::CfgW'(2)) < h_eff) && x_ok &&
                              !map_rdata[top_x_q];
    if (cnt_q >= FullDepth) begin
      cand = '0;
    end
  end

  always_comb begin
    n_cand = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
    prod   = 11'(rnd_q) * 11'(n_cand);
    pick   = prod[9:8];
    pick_dir = dmc_pkg::DirLeft;
    seen   = '0;
    found  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (!found && (seen == {1'b0, pick})) begin
          pick_dir = dmc_pkg::dir_e'(i[1:0]);
          found    = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  assign cnt_dec = cnt_q - dmc_pkg::DepthW'(1);

  always_comb begin
    case (dir_q)
      dmc_pkg::DirUp:   src_row = row_up_q;
      dmc_pkg::DirDown: src_row = row_dn_q;
      default:          src_row = row_mid_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    top_x_d   = top_x_q;
    top_y_d   = top_y_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    rnd_d     = rnd_q;
    row_mid_d = row_mid_q;
    row_up_d  = row_up_q;
    row_dn_d  = row_dn_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    wx_d      = wx_q;
    wy_d      = wy_q;
    dir_d     = dir_q;
    rsp_d     = rsp_q;

    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = '0;
    map_raddr = top_y_q;
    stk_we    = 1'b0;
    stk_waddr = cnt_q[dmc_pkg::StackAw-1:0];
    stk_wdata = {ny_q, nx_q};
    stk_raddr = dmc_pkg::StackAw'(cnt_q - dmc_pkg::DepthW'(2));

    case (state_q)
      SIdle: begin
        if (start) begin
          sx_d  = req_i.start_x;
          sy_d  = req_i.start_y;
          rnd_d = req_i.random_byte;
          if (req_i.action == dmc_pkg::ActStart) begin
            if (({1'b0, req_i.start_x} >= w_eff) || ({1'b0, req_i.start_y} >= h_eff)) begin
              done_d = 1'b1;
              rsp_d  = '0;
              rsp_d.status = dmc_pkg::StatRejected;
              rsp_d.depth  = cnt_q;
            end else begin
              clr_d   = '0;
              state_d = SClear;
            end
          end else if (cnt_q == '0) begin
            done_d = 1'b1;
            rsp_d  = '0;
            rsp_d.status = dmc_pkg::StatFinished;
          end else begin
            map_raddr = top_y_q;
            state_d   = SRdUp;
          end
        end
      end
      SClear: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = (clr_q == sy_q) ? (OneBit << sx_q) : '0;
        if (clr_q == '0) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {sy_q, sx_q};
        end
        clr_d = clr_q + dmc_pkg::RowW'(1);
        if (clr_q == LastRow) begin
          cnt_d   = dmc_pkg::DepthW'(1);
          top_x_d = sx_q;
          top_y_d = sy_q;
          done_d  = 1'b1;
          rsp_d   = '0;
          rsp_d.status = dmc_pkg::StatStarted;
          rsp_d.cell_x = sx_q;
          rsp_d.cell_y = sy_q;
          rsp_d.depth  = dmc_pkg::DepthW'(1);
          state_d = SIdle;
        end
      end
      SRdUp: begin
        row_mid_d = map_rdata;
        map_raddr = top_y_q - dmc_pkg::CoordW'(2);
        state_d   = SRdDn;
      end
      SRdDn: begin
        row_up_d  = map_rdata;
        map_raddr = top_y_q + dmc_pkg::CoordW'(2);
        state_d   = SEval;
      end
      SEval: begin
        row_dn_d = map_rdata;
        if (cand == '0) begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            done_d = 1'b1;
            rsp_d  = '0;
            rsp_d.status = dmc_pkg::StatBacktrack;
            state_d = SIdle;
          end else begin
            // new top sits one below the old one
            stk_raddr = dmc_pkg::StackAw'(cnt_q - dmc_pkg::DepthW'(2));
            state_d   = SPop;
          end
        end else begin
          dir_d = pick_dir;
          nx_d  = top_x_q;
          ny_d  = top_y_q;
          wx_d  = top_x_q;
          wy_d  = top_y_q;
          case (pick_dir)
            dmc_pkg::DirLeft: begin
              nx_d = top_x_q - dmc_pkg::CoordW'(2);
              wx_d = top_x_q - dmc_pkg::CoordW'(1);
            end
            dmc_pkg::DirRight: begin
              nx_d = top_x_q + dmc_pkg::CoordW'(2);
              wx_d = top_x_q + dmc_pkg::CoordW'(1);
            end
            dmc_pkg::DirUp: begin
              ny_d = top_y_q - dmc_pkg::CoordW'(2);
              wy_d = top_y_q - dmc_pkg::CoordW'(1);
            end
            default: begin
              ny_d = top_y_q + dmc_pkg::CoordW'(2);
              wy_d = top_y_q + dmc_pkg::CoordW'(1);
            end
          endcase
          state_d = SWrN;
        end
      end
      SWrN: begin
        map_we    = 1'b1;
        map_waddr = ny_q;
        stk_we    = 1'b1;
        stk_waddr = cnt_q[dmc_pkg::StackAw-1:0];
        stk_wdata = {ny_q, nx_q};
        if (dir_q == dmc_pkg::DirLeft || dir_q == dmc_pkg::DirRight) begin
          // wall and neighbor share the top cell's row
          map_wdata = src_row | (OneBit << nx_q) | (OneBit << wx_q);
          cnt_d   = cnt_q + dmc_pkg::DepthW'(1);
          top_x_d = nx_q;
          top_y_d = ny_q;
          done_d  = 1'b1;
          rsp_d.status = dmc_pkg::StatCarved;
          rsp_d.wall_x = wx_q;
          rsp_d.wall_y = wy_q;
          rsp_d.cell_x = nx_q;
          rsp_d.cell_y = ny_q;
          rsp_d.depth  = cnt_q + dmc_pkg::DepthW'(1);
          state_d = SIdle;
        end else begin
          map_wdata = src_row | (OneBit << nx_q);
          map_raddr = wy_q;
          state_d   = SWrW;
        end
      end
      SWrW: begin
        map_we    = 1'b1;
        map_waddr = wy_q;
        map_wdata = map_rdata | (OneBit << wx_q);
        cnt_d   = cnt_q + dmc_pkg::DepthW'(1);
        top_x_d = nx_q;
        top_y_d = ny_q;
        done_d  = 1'b1;
        rsp_d.status = dmc_pkg::StatCarved;
        rsp_d.wall_x = wx_q;
        rsp_d.wall_y = wy_q;
        rsp_d.cell_x = nx_q;
        rsp_d.cell_y = ny_q;
        rsp_d.depth  = cnt_q + dmc_pkg::DepthW'(1);
        state_d = SIdle;
      end
      SPop: begin
        top_x_d = stk_rdata[dmc_pkg::ColW-1:0];
        top_y_d = stk_rdata[dmc_pkg::StackW-1:dmc_pkg::ColW];
        done_d  = 1'b1;
        rsp_d   = '0;
        rsp_d.status = dmc_pkg::StatBacktrack;
        rsp_d.cell_x = stk_rdata[dmc_pkg::ColW-1:0];
        rsp_d.cell_y = stk_rdata[dmc_pkg::StackW-1:dmc_pkg::ColW];
        rsp_d.depth  = cnt_q;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      clr_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      grid_w_q <= MaxW;
      grid_h_q <= MaxH;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dmc_pkg::RegGridWidth:  grid_w_q <= cfg_wdata_i;
          dmc_pkg::RegGridHeight: grid_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_x_q   <= top_x_d;
    top_y_q   <= top_y_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    rnd_q     <= rnd_d;
    row_mid_q <= row_mid_d;
    row_up_q  <= row_up_d;
    row_dn_q  <= row_dn_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
    wx_q      <= wx_d;
    wy_q      <= wy_d;
    dir_q     <= dir_d;
    rsp_q     <= rsp_d;
  end

  dmc_ram #(
    .Width(dmc_pkg::MaxWidth),
    .Depth(dmc_pkg::MaxHeight)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  dmc_ram #(
    .Width(dmc_pkg::StackW),
    .Depth(dmc_pkg::StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == SIdle)
    else $error("result strobe outside idle");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullDepth)
    else $error("stack depth out of range");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClear && clr_q != LastRow) |=> state_q == SClear)
    else $error("clear sweep cut short");

  a_carve_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == dmc_pkg::StatCarved) |-> (rsp_o.depth == cnt_q && cnt_q > 1))
    else $error("carve depth does not match stack");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRdUp || state_q == SRdDn || state_q == SEval) |-> !map_we)
    else $error("map write during neighbor reads");

endmodule

/* hdl/dmc_ram.sv */
module dmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/dfs_maze_carver_unit_test.sv */
`timescale 1ns / 100ps

module dfs_maze_carver_unit_test;

  localparam int NumItems = 650;

  class maze_scoreboard;
    bit [dmc_pkg::MaxWidth-1:0]    open_row [dmc_pkg::MaxHeight];
    logic [dmc_pkg::CoordW-1:0]    path_x [dmc_pkg::StackDepth];
    logic [dmc_pkg::CoordW-1:0]    path_y [dmc_pkg::StackDepth];
    int unsigned                   path_len;
    logic [dmc_pkg::CfgW-1:0]      width_reg;
    logic [dmc_pkg::CfgW-1:0]      height_reg;
    dmc_pkg::rsp_t                 moves_due [$];
    int unsigned                   errors;

    function new();
      foreach (open_row[i]) open_row[i] = '0;
      path_len   = 0;
      width_reg  = dmc_pkg::CfgW'(dmc_pkg::MaxWidth);
      height_reg = dmc_pkg::CfgW'(dmc_pkg::MaxHeight);
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [dmc_pkg::CfgW-1:0] val);
      if (idx == dmc_pkg::RegGridWidth) width_reg = val;
      else height_reg = val;
    endfunction

    function int dim_in_use(logic [dmc_pkg::CfgW-1:0] val, int lim);
      if (val == 0) return 1;
      if (int'(val) > lim) return lim;
      return int'(val);
    endfunction

    // works out the result of one accepted request and updates the maze state
    function void predict_move(dmc_pkg::req_t r);
      dmc_pkg::rsp_t e;
      int   w, h, x, y, nx, ny, n, pick;
      int   cand_x [4];
      int   cand_y [4];
      e = '0;
      w = dim_in_use(width_reg, dmc_pkg::MaxWidth);
      h = dim_in_use(height_reg, dmc_pkg::MaxHeight);
      if (r.action == dmc_pkg::ActStart) begin
        if (int'(r.start_x) >= w || int'(r.start_y) >= h) begin
          e.status = dmc_pkg::StatRejected;
          e.depth  = dmc_pkg::DepthW'(path_len);
        end else begin
          foreach (open_row[i]) open_row[i] = '0;
          open_row[r.start_y][r.start_x] = 1'b1;
          path_x[0] = r.start_x;
          path_y[0] = r.start_y;
          path_len  = 1;
          e.status  = dmc_pkg::StatStarted;
          e.cell_x  = r.start_x;
          e.cell_y  = r.start_y;
          e.depth   = dmc_pkg::DepthW'(path_len);
        end
      end else if (path_len == 0) begin
        e.status = dmc_pkg::StatFinished;
      end else begin
        x = int'(path_x[path_len-1]);
        y = int'(path_y[path_len-1]);
        n = 0;
        // a full stack forces a backtrack
        if (path_len < dmc_pkg::StackDepth) begin
          for (int d = 0; d < 4; d++) begin
            nx = x;
            ny = y;
            case (dmc_pkg::dir_e'(d))
              dmc_pkg::DirLeft:  nx = x - 2;
              dmc_pkg::DirRight: nx = x + 2;
              dmc_pkg::DirUp:    ny = y - 2;
              default:           ny = y + 2;
            endcase
            if (nx >= 0 && ny >= 0 && nx < w && ny < h && !open_row[ny][nx]) begin
              cand_x[n] = nx;
              cand_y[n] = ny;
              n++;
            end
          end
        end
        if (n == 0) begin
          path_len--;
          e.status = dmc_pkg::StatBacktrack;
          e.depth  = dmc_pkg::DepthW'(path_len);
          if (path_len != 0) begin
            e.cell_x = path_x[path_len-1];
            e.cell_y = path_y[path_len-1];
          end
        end else begin
          pick = (int'(r.random_byte) * n) >> 8;
          nx = cand_x[pick];
          ny = cand_y[pick];
          e.wall_x = dmc_pkg::CoordW'((x + nx) / 2);
          e.wall_y = dmc_pkg::CoordW'((y + ny) / 2);
          open_row[e.wall_y][e.wall_x] = 1'b1;
          open_row[ny][nx] = 1'b1;
          path_x[path_len] = dmc_pkg::CoordW'(nx);
          path_y[path_len] = dmc_pkg::CoordW'(ny);
          path_len++;
          e.status = dmc_pkg::StatCarved;
          e.cell_x = dmc_pkg::CoordW'(nx);
          e.cell_y = dmc_pkg::CoordW'(ny);
          e.depth  = dmc_pkg::DepthW'(path_len);
        end
      end
      moves_due.push_back(e);
    endfunction

    function void cmp_field(string name, logic [dmc_pkg::DepthW-1:0] exp_v,
                            logic [dmc_pkg::DepthW-1:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_move(dmc_pkg::rsp_t got);
      dmc_pkg::rsp_t exp_r;
      if (moves_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = moves_due.pop_front();
      cmp_field("status", dmc_pkg::DepthW'(exp_r.status), dmc_pkg::DepthW'(got.status));
      cmp_field("wall_x", dmc_pkg::DepthW'(exp_r.wall_x), dmc_pkg::DepthW'(got.wall_x));
      cmp_field("wall_y", dmc_pkg::DepthW'(exp_r.wall_y), dmc_pkg::DepthW'(got.wall_y));
      cmp_field("cell_x", dmc_pkg::DepthW'(exp_r.cell_x), dmc_pkg::DepthW'(got.cell_x));
      cmp_field("cell_y", dmc_pkg::DepthW'(exp_r.cell_y), dmc_pkg::DepthW'(got.cell_y));
      cmp_field("depth", exp_r.depth, got.depth);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  dmc_pkg::req_t            req_i;
  logic                     done_o;
  dmc_pkg::rsp_t            rsp_o;
  logic                     cfg_we_i;
  logic                     cfg_idx_i;
  logic [dmc_pkg::CfgW-1:0] cfg_wdata_i;

  maze_scoreboard sb;
  int unsigned    n_sent;

  dfs_maze_carver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_move(rsp_o);
  end

  function automatic dmc_pkg::req_t mk_req(logic act, int x, int y, int rb);
    dmc_pkg::req_t r;
    r.action      = act;
    r.start_x     = dmc_pkg::CoordW'(x);
    r.start_y     = dmc_pkg::CoordW'(y);
    r.random_byte = 8'(rb);
    return r;
  endfunction

  function automatic int extreme_dim();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return dmc_pkg::MaxWidth;
      default: return (1 << dmc_pkg::CfgW) - 1;
    endcase
  endfunction

  // start may already be high from the previous request; it is only
  // lowered here when a gap is taken
  task automatic send_req(dmc_pkg::req_t r);
    @(negedge clk_i);
    while (!(n_sent >= 250 && n_sent < 400) && $urandom_range(0, 99) < 24) begin
      start = 1'b0;
      req_i = dmc_pkg::req_t'($bits(dmc_pkg::req_t)'($urandom));
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    sb.predict_move(r);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i) start = 1'b0;
    while (sb.moves_due.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = dmc_pkg::CfgW'(val);
    @(posedge clk_i);
    sb.set_reg(idx, dmc_pkg::CfgW'(val));
    @(negedge clk_i) cfg_we_i = 1'b0;
  endtask

  task automatic step_req(int rb);
    send_req(mk_req(dmc_pkg::ActStep, $urandom_range(0, 63), $urandom_range(0, 63), rb));
  endtask

  // one maze: new sizes, a start unless kept, then steps to carve and unwind
  task automatic run_maze_phase();
    int sel, w, h, ew, eh, steps;
    bit keep;
    drain();
    sel  = $urandom_range(0, 19);
    keep = ($urandom_range(0, 5) == 0);
    if (sel == 0) begin
      w = extreme_dim();
      h = extreme_dim();
    end else if (sel == 1) begin
      w = dmc_pkg::MaxWidth;
      h = dmc_pkg::MaxHeight;
    end else begin
      w = $urandom_range(1, 13);
      h = $urandom_range(1, 13);
    end
    write_reg(dmc_pkg::RegGridWidth, w);
    write_reg(dmc_pkg::RegGridHeight, h);
    ew = sb.dim_in_use(dmc_pkg::CfgW'(w), dmc_pkg::MaxWidth);
    eh = sb.dim_in_use(dmc_pkg::CfgW'(h), dmc_pkg::MaxHeight);
    if (ew * eh > 300) steps = $urandom_range(40, 120);
    else steps = 2 * ((ew + 1) / 2) * ((eh + 1) / 2) + $urandom_range(0, 3);
    if (keep) begin
      steps = $urandom_range(5, 30);
    end else if ($urandom_range(0, 9) == 0) begin
      send_req(mk_req(dmc_pkg::ActStart, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom));
    end else begin
      send_req(mk_req(dmc_pkg::ActStart, $urandom_range(0, ew - 1),
                      $urandom_range(0, eh - 1), $urandom));
    end
    for (int i = 0; i < steps && n_sent < NumItems; i++) begin
      // stray restart request now and then
      if ($urandom_range(0, 39) == 0)
        send_req(mk_req(dmc_pkg::ActStart, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom));
      else
        step_req($urandom_range(0, 255));
    end
  endtask

  initial begin
    sb          = new();
    n_sent      = 0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = dmc_pkg::RegGridWidth;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // full grid out of reset: empty-stack step, far and near corners
    send_req(mk_req(dmc_pkg::ActStep, 0, 0, 8'hff));
    send_req(mk_req(dmc_pkg::ActStart, 63, 63, 0));
    send_req(mk_req(dmc_pkg::ActStep, 63, 63, 8'h00));
    send_req(mk_req(dmc_pkg::ActStep, 0, 0, 8'hff));
    send_req(mk_req(dmc_pkg::ActStart, 0, 0, 8'h80));
    step_req(8'hff);
    step_req(8'h00);
    step_req(8'h80);
    drain();

    // zero sizes saturate to one cell: backtrack to empty, then rejects
    write_reg(dmc_pkg::RegGridWidth, 0);
    write_reg(dmc_pkg::RegGridHeight, 0);
    send_req(mk_req(dmc_pkg::ActStart, 0, 0, 0));
    step_req(8'h40);
    step_req(8'h40);
    send_req(mk_req(dmc_pkg::ActStart, 1, 0, 0));
    send_req(mk_req(dmc_pkg::ActStart, 0, 1, 0));
    drain();

    // oversize registers saturate to the full grid
    write_reg(dmc_pkg::RegGridWidth, 127);
    write_reg(dmc_pkg::RegGridHeight, 127);
    send_req(mk_req(dmc_pkg::ActStart, 63, 0, 0));
    step_req(8'hff);
    step_req(8'h00);
    drain();

    // rejected start keeps the maze going, then shrink mid-maze
    write_reg(dmc_pkg::RegGridWidth, 5);
    write_reg(dmc_pkg::RegGridHeight, 3);
    send_req(mk_req(dmc_pkg::ActStart, 2, 1, 0));
    step_req(8'h00);
    send_req(mk_req(dmc_pkg::ActStart, 5, 0, 8'hff));
    step_req(8'hff);
    step_req(8'h80);
    drain();
    write_reg(dmc_pkg::RegGridWidth, 2);
    step_req(8'h00);
    step_req(8'hff);
    step_req(8'h80);

    while (n_sent < NumItems) run_maze_phase();
    drain();
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
hdl/dmc_pkg.sv
hdl/dmc_ram.sv
hdl/dfs_maze_carver_unit.sv
tb/dfs_maze_carver_unit_test.sv
